FILE: rtl/rne_pkg.sv
// Shared types, codes and symbol tables for the Roman numeral encoder.
package rne_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned SymW     = 8;
  localparam int unsigned RemW     = 12;
  localparam int unsigned NumLvl   = 4;
  localparam int unsigned MaxRoman = 3999;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [SymW-1:0] SYM_NONE = 8'h00;
  localparam logic [SymW-1:0] SYM_I    = 8'h49;
  localparam logic [SymW-1:0] SYM_V    = 8'h56;
  localparam logic [SymW-1:0] SYM_X    = 8'h58;
  localparam logic [SymW-1:0] SYM_L    = 8'h4C;
  localparam logic [SymW-1:0] SYM_C    = 8'h43;
  localparam logic [SymW-1:0] SYM_D    = 8'h44;
  localparam logic [SymW-1:0] SYM_M    = 8'h4D;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_THOU,
    FS_HUND,
    FS_TENS,
    FS_PUSH
  } front_state_t;

  typedef logic [3:0] digit_t;

  // digs[3] thousands .. digs[0] units
  typedef struct packed {
    status_t               status;
    digit_t [NumLvl-1:0]   digs;
  } job_t;

  function automatic logic [SymW-1:0] one_sym(input logic [1:0] lvl);
    logic [SymW-1:0] s;
    case (lvl)
      2'd0:    s = SYM_I;
      2'd1:    s = SYM_X;
      2'd2:    s = SYM_C;
      default: s = SYM_M;
    endcase
    return s;
  endfunction

  function automatic logic [SymW-1:0] five_sym(input logic [1:0] lvl);
    logic [SymW-1:0] s;
    case (lvl)
      2'd0:    s = SYM_V;
      2'd1:    s = SYM_L;
      2'd2:    s = SYM_D;
      default: s = SYM_NONE;
    endcase
    return s;
  endfunction

  // Number of letters a decimal digit takes.
  function automatic logic [2:0] digit_len(input digit_t d);
    logic [2:0] n;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/rne_front.sv
// Front end: accepts values, classifies them and splits them into decimal digits.
module rne_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rne_pkg::ValueW-1:0]   in_tdata,   // [15:0] value
  output logic                         job_valid,
  input  logic                         job_ready,
  output rne_pkg::job_t                job
);
  import rne_pkg::*;

  front_state_t          state_r, state_nxt;
  logic [RemW-1:0]       rem_r, rem_nxt;
  digit_t [NumLvl-1:0]   digs_r, digs_nxt;
  status_t               status_r, status_nxt;

  logic                  in_acc;
  logic                  in_ok;
  status_t               in_status;
  logic [RemW-1:0]       step_rem;
  digit_t                step_dig;

  // One decade per call: largest k with k*sc <= r, and the remainder.
  function automatic logic [15:0] dig_sub(input logic [RemW-1:0] r, input logic [13:0] sc);
    logic [3:0]      d;
    logic [RemW-1:0] nr;
    logic [13:0]     lim;
    d  = 4'd0;
    nr = r;
    for (int k = 1; k <= 9; k++) begin
      lim = 14'(k) * sc;
      if ({2'b00, r} >= lim) begin
        d  = 4'(k);
        nr = RemW'({2'b00, r} - lim);
      end
    end
    return {d, nr};
  endfunction

  always_comb begin
    in_ok     = (in_tdata != '0) && (in_tdata <= ValueW'(MaxRoman));
    in_status = (in_tdata == '0) ? ST_EMPTY : (in_ok ? ST_OK : ST_RANGE);
  end

  // outputs
  always_comb begin
    in_tready = (state_r == FS_IDLE) || ((state_r == FS_PUSH) && job_ready);
    job_valid = (state_r == FS_PUSH);
    job.status = status_r;
    job.digs   = digs_r;
  end

  assign in_acc = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (in_acc) begin
          state_nxt = in_ok ? FS_THOU : FS_PUSH;
        end
      end
      FS_THOU: state_nxt = FS_HUND;
      FS_HUND: state_nxt = FS_TENS;
      FS_TENS: state_nxt = FS_PUSH;
      FS_PUSH: begin
        if (in_acc) begin
          state_nxt = in_ok ? FS_THOU : FS_PUSH;
        end else if (job_ready) begin
          state_nxt = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  // digit extraction, one decade per cycle
  always_comb begin
    {step_dig, step_rem} = 16'd0;
    case (state_r)
      FS_THOU: {step_dig, step_rem} = dig_sub(rem_r, 14'd1000);
      FS_HUND: {step_dig, step_rem} = dig_sub(rem_r, 14'd100);
      FS_TENS: {step_dig, step_rem} = dig_sub(rem_r, 14'd10);
      default: {step_dig, step_rem} = {4'd0, rem_r};
    endcase
  end

  always_comb begin
    rem_nxt    = rem_r;
    digs_nxt   = digs_r;
    status_nxt = status_r;
    if (in_acc) begin
      rem_nxt    = in_tdata[RemW-1:0];
      digs_nxt   = '0;
      status_nxt = in_status;
    end else begin
      case (state_r)
        FS_THOU: begin
          digs_nxt[3] = step_dig;
          rem_nxt     = step_rem;
        end
        FS_HUND: begin
          digs_nxt[2] = step_dig;
          rem_nxt     = step_rem;
        end
        FS_TENS: begin
          digs_nxt[1] = step_dig;
          digs_nxt[0] = step_rem[3:0];
          rem_nxt     = step_rem;
        end
        default: rem_nxt = rem_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    digs_r   <= digs_nxt;
    status_r <= status_nxt;
  end

  a_ok_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && (job.status == ST_OK) |-> (job.digs != '0))
    else $error("front: ok word with no digits");

  a_units_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && (job.status == ST_OK) |-> (job.digs[0] <= 4'd9) && (job.digs[3] <= 4'd3))
    else $error("front: digit out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("front: job changed while stalled");

endmodule

FILE: rtl/rne_queue.sv
// Two-entry queue of digit jobs between front and back.
module rne_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rne_pkg::job_t  push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rne_pkg::job_t  pop_job
);
  import rne_pkg::*;

  job_t              mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCntW'(QDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCntW'(QDepth))
    else $error("queue: count overflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == QCntW'(QDepth)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue: pointers disagree with count");

  a_pop_then_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue: pop did not drop count");

endmodule

FILE: rtl/rne_back.sv
// Back end: walks a digit job and emits one Roman letter per word.
module rne_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  rne_pkg::job_t               job,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rne_pkg::SymW-1:0]    out_tdata,   // [7:0] symbol
  output logic                        out_tlast,   // last
  output logic [1:0]                  out_tuser    // [1:0] status
);
  import rne_pkg::*;

  logic                  have_r, have_nxt;
  digit_t [NumLvl-1:0]   digs_r, digs_nxt;
  status_t               stat_r, stat_nxt;
  logic [1:0]            pos_r, pos_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [SymW-1:0]       osym_r, osym_nxt;
  logic                  olast_r, olast_nxt;
  status_t               ostat_r, ostat_nxt;

  logic [NumLvl-1:0]     nz, rest;
  logic [1:0]            cur;
  digit_t                d;
  logic [2:0]            len;
  logic                  fin_dig, finish, adv, emit, load;
  logic [SymW-1:0]       sym_o, sym_f, sym_t, sym;

  always_comb begin
    for (int i = 0; i < NumLvl; i++) begin
      nz[i] = (digs_r[i] != '0);
    end
    cur = '0;
    for (int i = 0; i < NumLvl; i++) begin
      if (nz[i]) begin
        cur = 2'(i);
      end
    end
    rest    = nz & ~(NumLvl'(1) << cur);
    d       = digs_r[cur];
    len     = digit_len(d);
    fin_dig = ({1'b0, pos_r} == (len - 3'd1));
    sym_o   = one_sym(cur);
    sym_f   = five_sym(cur);
    sym_t   = one_sym(cur + 2'd1);
    case (d)
      4'd9:    sym = (pos_r == 2'd0) ? sym_o : sym_t;
      4'd4:    sym = (pos_r == 2'd0) ? sym_o : sym_f;
      default: sym = ((d >= 4'd5) && (pos_r == 2'd0)) ? sym_f : sym_o;
    endcase
  end

  assign adv       = !ovalid_r || out_tready;
  assign emit      = have_r && adv;
  assign finish    = (stat_r != ST_OK) || (fin_dig && (rest == '0));
  assign load      = job_valid && (!have_r || (emit && finish));
  assign job_ready = load;

  always_comb begin
    have_nxt   = have_r;
    digs_nxt   = digs_r;
    stat_nxt   = stat_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r;
    osym_nxt   = osym_r;
    olast_nxt  = olast_r;
    ostat_nxt  = ostat_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      ostat_nxt  = stat_r;
      if (stat_r != ST_OK) begin
        osym_nxt  = SYM_NONE;
        olast_nxt = 1'b1;
      end else begin
        osym_nxt  = sym;
        olast_nxt = finish;
        // advance within the digit or retire it
        if (fin_dig) begin
          digs_nxt[cur] = '0;
          pos_nxt       = '0;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      if (finish) begin
        have_nxt = 1'b0;
      end
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (load) begin
      have_nxt = 1'b1;
      digs_nxt = job.digs;
      stat_nxt = job.status;
      pos_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      have_r   <= have_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digs_r  <= digs_nxt;
    stat_r  <= stat_nxt;
    pos_r   <= pos_nxt;
    osym_r  <= osym_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = osym_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = ostat_r;

  a_flag_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tlast && (out_tdata == SYM_NONE))
    else $error("back: flagged word not a lone last word");

  a_ok_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK) |-> (out_tdata != SYM_NONE))
    else $error("back: ok word without a letter");

  a_ok_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    have_r && (stat_r == ST_OK) |-> (digs_r != '0) && ({1'b0, pos_r} < len))
    else $error("back: active job with nothing left");

endmodule

FILE: rtl/roman_numeral_encoder.sv
// Letters leave one per cycle while out_tready holds and a job is waiting, 1 to 15
// letters per valid value. The front digit splitter does one decade compare per cycle
// and takes no new value until the job of the last one is handed on; the output
// runs at one word per cycle while a job is waiting, unless out_tready stalls it.
// A two-entry job queue lets the splitter run ahead of the letter sequencer.
// Reset: synchronous active-low rst_n empties the front, queue and output register.
module roman_numeral_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rne_pkg::ValueW-1:0]  in_tdata,    // [15:0] value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rne_pkg::SymW-1:0]    out_tdata,   // [7:0] symbol
  output logic                        out_tlast,   // last
  output logic [1:0]                  out_tuser    // [1:0] status
);
  import rne_pkg::*;

  logic  f_valid, f_ready;
  job_t  f_job;
  logic  b_valid, b_ready;
  job_t  b_job;

  rne_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  rne_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  rne_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (b_valid),
    .job_ready  (b_ready),
    .job        (b_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
